// File: design/bps_pkg.sv
// Shared types, register map, reset values and phase helpers for the buzzer
// pattern sequencer. No dependencies.
package bps_pkg;

	localparam int unsigned CfgAddrW = 5;
	localparam int unsigned CfgDataW = 32;
	localparam int unsigned LenW     = 16;
	localparam int unsigned CountW   = 16;

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_SINGLE_BEEP = 3'd0;
	localparam reg_idx_t REG_WARN_BEEP   = 3'd1;
	localparam reg_idx_t REG_WARN_GAP    = 3'd2;
	localparam reg_idx_t REG_WARN_TAIL   = 3'd3;
	localparam reg_idx_t REG_ERROR_ON    = 3'd4;
	localparam reg_idx_t REG_ERROR_OFF   = 3'd5;

	localparam logic [LenW-1:0] SINGLE_BEEP_RST = 16'd100;
	localparam logic [LenW-1:0] WARN_BEEP_RST   = 16'd50;
	localparam logic [LenW-1:0] WARN_GAP_RST    = 16'd200;
	localparam logic [LenW-1:0] WARN_TAIL_RST   = 16'd700;
	localparam logic [LenW-1:0] ERROR_ON_RST    = 16'd1000;
	localparam logic [LenW-1:0] ERROR_OFF_RST   = 16'd1000;

	typedef enum logic [1:0] {
		TONE_SINGLE = 2'd0,
		TONE_WARN   = 2'd1,
		TONE_ERROR  = 2'd2,
		TONE_STOP   = 2'd3
	} tone_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_S_ON   = 3'd1,
		PH_W_ON1  = 3'd2,
		PH_W_GAP  = 3'd3,
		PH_W_ON2  = 3'd4,
		PH_W_TAIL = 3'd5,
		PH_E_ON   = 3'd6,
		PH_E_OFF  = 3'd7
	} phase_t;

	typedef struct packed {
		logic [LenW-1:0] single_beep;
		logic [LenW-1:0] warn_beep;
		logic [LenW-1:0] warn_gap;
		logic [LenW-1:0] warn_tail;
		logic [LenW-1:0] error_on;
		logic [LenW-1:0] error_off;
	} cfg_t;

	typedef struct packed {
		logic              mode;
		logic [1:0]        tone;
		logic [CountW-1:0] count;
	} item_t;

	typedef struct packed {
		logic bell;
		logic busy;
	} res_t;

	// Zero length counts as one tick.
	function automatic logic [LenW-1:0] min_one(input logic [LenW-1:0] v);
		return (v == '0) ? LenW'(1) : v;
	endfunction

	function automatic logic [LenW-1:0] phase_len(input phase_t ph, input cfg_t c);
		logic [LenW-1:0] len;
		case (ph)
			PH_S_ON:   len = min_one(c.single_beep);
			PH_W_ON1:  len = min_one(c.warn_beep);
			PH_W_GAP:  len = min_one(c.warn_gap);
			PH_W_ON2:  len = min_one(c.warn_beep);
			PH_W_TAIL: len = min_one(c.warn_tail);
			PH_E_ON:   len = min_one(c.error_on);
			PH_E_OFF:  len = min_one(c.error_off);
			default:   len = '0;
		endcase
		return len;
	endfunction

	function automatic phase_t first_phase(input tone_t t);
		phase_t ph;
		case (t)
			TONE_SINGLE: ph = PH_S_ON;
			TONE_WARN:   ph = PH_W_ON1;
			TONE_ERROR:  ph = PH_E_ON;
			default:     ph = PH_IDLE;
		endcase
		return ph;
	endfunction

	function automatic logic phase_bell(input phase_t ph);
		return (ph == PH_S_ON) || (ph == PH_W_ON1) || (ph == PH_W_ON2) || (ph == PH_E_ON);
	endfunction

endpackage

// File: design/bps_regs.sv
// APB-style register file holding the six phase lengths.
// Depends on bps_pkg.
module bps_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [bps_pkg::CfgAddrW-1:0]     paddr,
	input  logic [bps_pkg::CfgDataW-1:0]     pwdata,
	output logic [bps_pkg::CfgDataW-1:0]     prdata,
	output bps_pkg::cfg_t                    cfg
);
	import bps_pkg::*;

	cfg_t            cfg_q;
	reg_idx_t        idx;
	logic            wr_en;
	logic [LenW-1:0] wval;
	logic [LenW-1:0] rval;

	assign idx   = paddr[CfgAddrW-1:2];
	assign wr_en = psel && penable && pwrite;
	assign wval  = pwdata[LenW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.single_beep <= SINGLE_BEEP_RST;
			cfg_q.warn_beep   <= WARN_BEEP_RST;
			cfg_q.warn_gap    <= WARN_GAP_RST;
			cfg_q.warn_tail   <= WARN_TAIL_RST;
			cfg_q.error_on    <= ERROR_ON_RST;
			cfg_q.error_off   <= ERROR_OFF_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_SINGLE_BEEP: cfg_q.single_beep <= wval;
				REG_WARN_BEEP:   cfg_q.warn_beep   <= wval;
				REG_WARN_GAP:    cfg_q.warn_gap    <= wval;
				REG_WARN_TAIL:   cfg_q.warn_tail   <= wval;
				REG_ERROR_ON:    cfg_q.error_on    <= wval;
				REG_ERROR_OFF:   cfg_q.error_off   <= wval;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_SINGLE_BEEP: rval = cfg_q.single_beep;
			REG_WARN_BEEP:   rval = cfg_q.warn_beep;
			REG_WARN_GAP:    rval = cfg_q.warn_gap;
			REG_WARN_TAIL:   rval = cfg_q.warn_tail;
			REG_ERROR_ON:    rval = cfg_q.error_on;
			REG_ERROR_OFF:   rval = cfg_q.error_off;
			default:         rval = '0;
		endcase
	end

	assign prdata = CfgDataW'(rval);
	assign cfg    = cfg_q;

endmodule

// File: design/bps_core.sv
// Pattern state machine: phase, phase timer, repeat and pending-command state,
// updated once per item. Depends on bps_pkg.
module bps_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  bps_pkg::item_t item,
	input  bps_pkg::cfg_t  cfg,
	output bps_pkg::res_t  res
);
	import bps_pkg::*;

	phase_t              phase_q, phase_d;
	logic [LenW-1:0]     timer_q, timer_d;
	logic [CountW-1:0]   left_q, left_d;
	logic                forever_q, forever_d;
	tone_t               active_q, active_d;
	logic                pvalid_q, pvalid_d;
	tone_t               ptone_q, ptone_d;
	logic [CountW-1:0]   pcount_q, pcount_d;

	logic                take_en;
	tone_t               take_tone;
	logic [CountW-1:0]   take_cnt;
	logic                take_rep;
	logic                start_en;
	tone_t               start_tone;
	logic                enter_en;
	phase_t              enter_ph;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			timer_q   <= '0;
			left_q    <= '0;
			forever_q <= 1'b0;
			active_q  <= TONE_SINGLE;
			pvalid_q  <= 1'b0;
			ptone_q   <= TONE_SINGLE;
			pcount_q  <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			timer_q   <= timer_d;
			left_q    <= left_d;
			forever_q <= forever_d;
			active_q  <= active_d;
			pvalid_q  <= pvalid_d;
			ptone_q   <= ptone_d;
			pcount_q  <= pcount_d;
		end
	end

	// Next state for one item: command or tick.
	always_comb begin
		phase_d    = phase_q;
		timer_d    = timer_q;
		left_d     = left_q;
		forever_d  = forever_q;
		active_d   = active_q;
		pvalid_d   = pvalid_q;
		ptone_d    = ptone_q;
		pcount_d   = pcount_q;
		take_en    = 1'b0;
		take_tone  = ptone_q;
		take_cnt   = pcount_q;
		take_rep   = 1'b0;
		start_en   = 1'b0;
		start_tone = active_q;
		enter_en   = 1'b0;
		enter_ph   = PH_IDLE;

		if (item.mode) begin
			pvalid_d = 1'b1;
			ptone_d  = tone_t'(item.tone);
			pcount_d = item.count;
			if (phase_q == PH_IDLE) begin
				take_en   = 1'b1;
				take_tone = tone_t'(item.tone);
				take_cnt  = item.count;
			end
		end else if (phase_q != PH_IDLE) begin
			if (timer_q > LenW'(1)) begin
				timer_d = timer_q - LenW'(1);
			end else begin
				unique case (phase_q)
					PH_W_ON1: begin
						enter_en = 1'b1;
						enter_ph = PH_W_GAP;
					end
					PH_W_GAP: begin
						enter_en = 1'b1;
						enter_ph = PH_W_ON2;
					end
					PH_W_ON2: begin
						enter_en = 1'b1;
						enter_ph = PH_W_TAIL;
					end
					PH_E_ON: begin
						enter_en = 1'b1;
						enter_ph = PH_E_OFF;
					end
					default: begin
						// end of a repetition
						if (pvalid_q) begin
							take_en = 1'b1;
						end else if (forever_q) begin
							start_en = 1'b1;
						end else if (left_q != '0) begin
							left_d   = left_q - CountW'(1);
							start_en = 1'b1;
						end else begin
							enter_en = 1'b1;
						end
					end
				endcase
			end
		end

		if (take_en) begin
			take_rep   = (take_tone == TONE_WARN) || (take_tone == TONE_ERROR);
			pvalid_d   = 1'b0;
			active_d   = take_tone;
			forever_d  = take_rep && (take_cnt == '0);
			left_d     = (take_rep && (take_cnt != '0)) ? take_cnt - CountW'(1) : '0;
			start_en   = 1'b1;
			start_tone = take_tone;
		end
		if (start_en) begin
			enter_en = 1'b1;
			enter_ph = first_phase(start_tone);
		end
		if (enter_en) begin
			phase_d = enter_ph;
			timer_d = phase_len(enter_ph, cfg);
		end
	end

	// Result for this item follows from the phase it leaves behind.
	always_comb begin
		res.bell = phase_bell(phase_d);
		res.busy = (phase_d != PH_IDLE);
	end

endmodule

// File: design/buzzer_pattern_sequencer_unit.sv
// Buzzer pattern sequencer top level: input register, pattern core, result
// register and the APB-style configuration port. Depends on bps_pkg, bps_regs, bps_core.
//
//  channel   handshake               payload
//  -------   ---------------------   -----------------------------
//  in        in_valid / in_ready     mode, tone, repeat_count
//  out       out_valid / out_ready   bell_on, busy_res
//  cfg       psel/penable/pwrite     paddr, pwdata -> prdata, pready
//
// Each item lands in the input register; when it moves on, the core's
// next-state logic updates the pattern state and the result register is
// loaded. An item can be taken every cycle while results drain.
// Output stall: the result register holds, the input register holds its item,
// and in_ready drops only when both are full. Reset clears state, handshake
// valids and the registers to their default lengths; no clearing pass.
module buzzer_pattern_sequencer_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	// item input
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             mode,
	input  logic [1:0]                       tone,
	input  logic [bps_pkg::CountW-1:0]       repeat_count,
	// result output
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             bell_on,
	output logic                             busy_res,
	// configuration
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [bps_pkg::CfgAddrW-1:0]     paddr,
	input  logic [bps_pkg::CfgDataW-1:0]     pwdata,
	output logic [bps_pkg::CfgDataW-1:0]     prdata,
	output logic                             pready
);
	import bps_pkg::*;

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	res_t  res;
	res_t  res_s2;
	logic  valid_s2;
	logic  advance;

	assign pready = 1'b1;

	bps_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// The held item moves on whenever the result register is free or draining.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.mode  <= mode;
			item_s1.tone  <= tone;
			item_s1.count <= repeat_count;
		end
	end

	bps_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign bell_on   = res_s2.bell;
	assign busy_res  = res_s2.busy;

	// The bell never sounds while no pattern plays.
	a_bell_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(res_s2.bell && !res_s2.busy))
		else $error("bell on while idle");

	// A held item that cannot move on stays put.
	a_s1_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("input register item lost");

	// Back-pressure only when both registers are full and the output stalls.
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && valid_s2 && !out_ready))
		else $error("in_ready low without a full stall");

	// A result appears in the cycle after its item moves on.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("result missing after advance");

endmodule
